>>> rtl/core/paft_pkg.sv
// ============================================================================
// paft_pkg : shared definitions for the point affine transform unit
// Register map codes and fixed sizes used by the lanes, merge and top level.
// ============================================================================
package paft_pkg;

    // Three axes per point, one lane per matrix row
    localparam int AXES = 3;

    // Configuration port geometry: 64-bit data, registers on 8-byte strides
    localparam int DATA_BITS = 64;
    localparam int ADDR_BITS = 6;
    localparam int REG_LSB   = 3;
    localparam int IDX_BITS  = ADDR_BITS - REG_LSB;

    // Register indexes
    typedef enum logic [IDX_BITS-1:0] {
        REG_ROW_X = 3'd0,
        REG_ROW_Y = 3'd1,
        REG_ROW_Z = 3'd2,
        REG_OFF_X = 3'd3,
        REG_OFF_Y = 3'd4,
        REG_OFF_Z = 3'd5
    } reg_index_t;

endpackage

>>> rtl/core/paft_lane.sv
// ============================================================================
// paft_lane : one matrix row of the transform
// Three coefficient products, offset add with rounding bias, then the
// rounded sum taken down to coordinate scale. Three register stages.
// ============================================================================
module paft_lane #(
    parameter int COORD_BITS = 24,
    parameter int COEF_BITS  = 18
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [COORD_BITS-1:0]           point_x,
    input  logic signed [COORD_BITS-1:0]           point_y,
    input  logic signed [COORD_BITS-1:0]           point_z,
    input  logic        [3*COEF_BITS-1:0]          row,
    input  logic signed [COORD_BITS-1:0]           offset,
    output logic                                   out_valid,
    output logic signed [COORD_BITS+3:0]           out_value
);

    localparam int PROD_W = COORD_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 2;
    localparam int FRAC   = COEF_BITS - 2;
    localparam int SUM_W  = ACC_W - FRAC;

    logic signed [COEF_BITS-1:0] coef [paft_pkg::AXES];
    logic signed [PROD_W-1:0]    prod_next [paft_pkg::AXES];
    logic signed [PROD_W-1:0]    prod_reg  [paft_pkg::AXES];
    logic signed [PROD_W-3:0]    off_term;
    logic signed [ACC_W-1:0]     sum_a_next, sum_b_next;
    logic signed [ACC_W-1:0]     sum_a_reg, sum_b_reg;
    logic signed [ACC_W-1:0]     total;
    logic signed [SUM_W-1:0]     value_next, value_reg;
    logic [2:0]                  valid_reg;

    // Unpack row coefficients, column 0 in the low bits
    always_comb
    begin
        coef[0] = $signed(row[COEF_BITS-1:0]);
        coef[1] = $signed(row[2*COEF_BITS-1:COEF_BITS]);
        coef[2] = $signed(row[3*COEF_BITS-1:2*COEF_BITS]);
    end

    // Stage 1: products
    always_comb
    begin
        prod_next[0] = point_x * coef[0];
        prod_next[1] = point_y * coef[1];
        prod_next[2] = point_z * coef[2];
    end

    // Offset at product scale, with the half-LSB rounding bias in the zero bits
    assign off_term = $signed({offset, 1'b1, {(FRAC-1){1'b0}}});

    // Stage 2: pairwise partial sums
    always_comb
    begin
        sum_a_next = {{2{prod_reg[0][PROD_W-1]}}, prod_reg[0]}
                   + {{2{prod_reg[1][PROD_W-1]}}, prod_reg[1]};
        sum_b_next = {{2{prod_reg[2][PROD_W-1]}}, prod_reg[2]}
                   + {{4{off_term[PROD_W-3]}}, off_term};
    end

    // Stage 3: full sum, floor by dropping the fraction bits
    assign total      = sum_a_reg + sum_b_reg;
    assign value_next = total[ACC_W-1:FRAC];

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg[0] <= prod_next[0];
        prod_reg[1] <= prod_next[1];
        prod_reg[2] <= prod_next[2];
        sum_a_reg   <= sum_a_next;
        sum_b_reg   <= sum_b_next;
        value_reg   <= value_next;
    end

    // Beat tracking down the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    assign out_valid = valid_reg[2];
    assign out_value = value_reg;

endmodule

>>> rtl/core/paft_merge.sv
// ============================================================================
// paft_merge : saturation and result register
// Clamps each lane value to the coordinate range, ORs the clip flags and
// registers the result beat.
// ============================================================================
module paft_merge #(
    parameter int COORD_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_BITS+3:0]  lane_value [paft_pkg::AXES],
    output logic                          result_valid,
    output logic signed [COORD_BITS-1:0]  result_x,
    output logic signed [COORD_BITS-1:0]  result_y,
    output logic signed [COORD_BITS-1:0]  result_z,
    output logic                          clipped
);

    localparam int SUM_W = COORD_BITS + 4;

    logic signed [COORD_BITS-1:0] sat_value [paft_pkg::AXES];
    logic [paft_pkg::AXES-1:0]    lane_clip;
    logic signed [COORD_BITS-1:0] res_reg   [paft_pkg::AXES];
    logic                         valid_reg, clip_reg;
    logic                         clip_next;

    // Per-lane clamp: overflow when the top bits are not a plain sign run
    always_comb
    begin
        for (int i = 0; i < paft_pkg::AXES; i++)
        begin
            lane_clip[i] = !((&lane_value[i][SUM_W-1:COORD_BITS-1])
                           || !(|lane_value[i][SUM_W-1:COORD_BITS-1]));
            if (!lane_clip[i])
                sat_value[i] = lane_value[i][COORD_BITS-1:0];
            else if (lane_value[i][SUM_W-1])
                sat_value[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
            else
                sat_value[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    end

    assign clip_next = in_valid && (|lane_clip);

    // Result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < paft_pkg::AXES; i++)
            res_reg[i] <= sat_value[i];
    end

    // Strobe and flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            clip_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            clip_reg  <= clip_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_x     = res_reg[0];
    assign result_y     = res_reg[1];
    assign result_z     = res_reg[2];
    assign clipped      = clip_reg;

endmodule

>>> rtl/core/point_affine_transform_unit.sv
// ============================================================================
// point_affine_transform_unit : 3-D affine point transform, out = M*p + t
// Three row lanes in parallel feed a merge stage that saturates and flags.
// ============================================================================
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ------------------------------
//  command   in         start && !busy        point_x, point_y, point_z
//  result    out        result_valid strobe   result_x/y/z, clipped
//  config    in/out     APB, pready tied high matrix rows, offsets
//
//  One point accepted every cycle; busy stays low.
//  From accept to the result strobe a point passes the product, partial
//  sum, full sum/round and saturate/result register stages.
//  Reset (rst_n low, asynchronous) empties the pipeline and loads the
//  identity matrix with zero offsets.
//  The result beat lasts one cycle and cannot be stalled by the receiver.
//
module point_affine_transform_unit #(
    parameter int COORD_BITS = 24,
    parameter int COEF_BITS  = 18
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // command channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_BITS-1:0]         point_x,
    input  logic signed [COORD_BITS-1:0]         point_y,
    input  logic signed [COORD_BITS-1:0]         point_z,
    // result channel
    output logic                                 result_valid,
    output logic signed [COORD_BITS-1:0]         result_x,
    output logic signed [COORD_BITS-1:0]         result_y,
    output logic signed [COORD_BITS-1:0]         result_z,
    output logic                                 clipped,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [paft_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [paft_pkg::DATA_BITS-1:0]       pwdata,
    output logic [paft_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready
);

    localparam int ROW_W = 3 * COEF_BITS;
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << (COEF_BITS - 2);

    paft_pkg::reg_index_t         reg_idx;
    logic                         cfg_write;
    logic [ROW_W-1:0]             row_reg  [paft_pkg::AXES];
    logic [ROW_W-1:0]             row_next [paft_pkg::AXES];
    logic signed [COORD_BITS-1:0] off_reg  [paft_pkg::AXES];
    logic signed [COORD_BITS-1:0] off_next [paft_pkg::AXES];
    logic                         accept;
    logic [paft_pkg::AXES-1:0]    lane_valid;
    logic signed [COORD_BITS+3:0] lane_value [paft_pkg::AXES];

    // Command handshake: the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;

    // Register decode
    assign reg_idx   = paft_pkg::reg_index_t'(paddr[paft_pkg::ADDR_BITS-1:paft_pkg::REG_LSB]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Next values of the configuration registers
    always_comb
    begin
        for (int i = 0; i < paft_pkg::AXES; i++)
        begin
            row_next[i] = row_reg[i];
            off_next[i] = off_reg[i];
        end
        if (cfg_write)
        begin
            case (reg_idx)
                paft_pkg::REG_ROW_X: row_next[0] = pwdata[ROW_W-1:0];
                paft_pkg::REG_ROW_Y: row_next[1] = pwdata[ROW_W-1:0];
                paft_pkg::REG_ROW_Z: row_next[2] = pwdata[ROW_W-1:0];
                paft_pkg::REG_OFF_X: off_next[0] = $signed(pwdata[COORD_BITS-1:0]);
                paft_pkg::REG_OFF_Y: off_next[1] = $signed(pwdata[COORD_BITS-1:0]);
                paft_pkg::REG_OFF_Z: off_next[2] = $signed(pwdata[COORD_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // Configuration registers, identity matrix at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= {{(2*COEF_BITS){1'b0}}, COEF_ONE};
            row_reg[1] <= {{COEF_BITS{1'b0}}, COEF_ONE, {COEF_BITS{1'b0}}};
            row_reg[2] <= {COEF_ONE, {(2*COEF_BITS){1'b0}}};
            for (int i = 0; i < paft_pkg::AXES; i++)
                off_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < paft_pkg::AXES; i++)
            begin
                row_reg[i] <= row_next[i];
                off_reg[i] <= off_next[i];
            end
        end
    end

    // Read-back, zero-extended
    always_comb
    begin
        case (reg_idx)
            paft_pkg::REG_ROW_X: prdata = {{(paft_pkg::DATA_BITS-ROW_W){1'b0}}, row_reg[0]};
            paft_pkg::REG_ROW_Y: prdata = {{(paft_pkg::DATA_BITS-ROW_W){1'b0}}, row_reg[1]};
            paft_pkg::REG_ROW_Z: prdata = {{(paft_pkg::DATA_BITS-ROW_W){1'b0}}, row_reg[2]};
            paft_pkg::REG_OFF_X: prdata = {{(paft_pkg::DATA_BITS-COORD_BITS){1'b0}}, off_reg[0]};
            paft_pkg::REG_OFF_Y: prdata = {{(paft_pkg::DATA_BITS-COORD_BITS){1'b0}}, off_reg[1]};
            paft_pkg::REG_OFF_Z: prdata = {{(paft_pkg::DATA_BITS-COORD_BITS){1'b0}}, off_reg[2]};
            default:             prdata = '0;
        endcase
    end

    // One lane per matrix row
    for (genvar r = 0; r < paft_pkg::AXES; r++)
    begin : g_lane
        paft_lane #(
            .COORD_BITS (COORD_BITS),
            .COEF_BITS  (COEF_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (accept),
            .point_x   (point_x),
            .point_y   (point_y),
            .point_z   (point_z),
            .row       (row_reg[r]),
            .offset    (off_reg[r]),
            .out_valid (lane_valid[r]),
            .out_value (lane_value[r])
        );
    end

    // Saturate and merge the lanes
    paft_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (lane_valid[0]),
        .lane_value   (lane_value),
        .result_valid (result_valid),
        .result_x     (result_x),
        .result_y     (result_y),
        .result_z     (result_z),
        .clipped      (clipped)
    );

endmodule

>>> rtl/core/paft_checker.sv
// ============================================================================
// paft_checker : port-level checks for the point affine transform unit
// Fixed latency between command and result beats, and flag qualification.
// ============================================================================
module paft_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         result_valid,
    input logic signed [COORD_BITS-1:0] result_x,
    input logic                         clipped
);

    // Every accepted command beat gives a matching result beat
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 result_valid)
        else $error("result beat missing after accepted command");

    // No result beat without an earlier command beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##4 !result_valid)
        else $error("result beat without a command");

    // Clip flag only rides on a result beat
    a_clip_qualified: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !clipped)
        else $error("clipped raised outside a result beat");

    // A result beat carries known data on the x axis
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$isunknown(result_x))
        else $error("result beat carries unknown data");

endmodule

bind point_affine_transform_unit paft_checker #(
    .COORD_BITS (COORD_BITS)
) u_paft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result_x     (result_x),
    .clipped      (clipped)
);
